FILE: design/srle_pkg.sv
// Shared types, constants and packet formatting for the scan-line run-length encoder.
`default_nettype none

package srle_pkg;

  localparam int unsigned SampleW    = 8;
  localparam int unsigned PixelW     = 4 * SampleW;
  localparam int unsigned CountW     = 8;
  localparam int unsigned ColW       = 16;
  localparam int unsigned PktBytesW  = 3;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CountW-1:0] RunLimit      = 8'd255;
  localparam logic [1:0]        FormatReset   = 2'd1;
  localparam logic [ColW-1:0]   RowLenReset   = 16'd640;

  localparam logic [CfgIdxW-1:0] CFG_PIXEL_FORMAT   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_PIXELS_PER_ROW = 1'd1;

  typedef enum logic [1:0] {
    FMT_MONO = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_RGBA = 2'd2
  } pix_fmt_e;

  localparam logic [PktBytesW-1:0] BytesMono = 3'd2;
  localparam logic [PktBytesW-1:0] BytesRgb  = 3'd4;
  localparam logic [PktBytesW-1:0] BytesRgba = 3'd5;

  typedef struct packed {
    logic [CountW-1:0]    run_length;
    logic [SampleW-1:0]   byte_a;
    logic [SampleW-1:0]   byte_b;
    logic [SampleW-1:0]   byte_c;
    logic [SampleW-1:0]   byte_d;
    logic [PktBytesW-1:0] packet_bytes;
    logic                 last_of_item;
  } pkt_t;

  typedef struct packed {
    logic [1:0] num;
    pkt_t       first;
    pkt_t       second;
  } push_t;

  function automatic pkt_t build_pkt(logic [PixelW-1:0] pix, logic [CountW-1:0] cnt,
                                     logic [1:0] fmt, logic last);
    pkt_t p;
    p.run_length   = cnt;
    p.last_of_item = last;
    case (pix_fmt_e'(fmt))
      FMT_MONO: begin
        p.byte_a       = pix[7:0];
        p.byte_b       = '0;
        p.byte_c       = '0;
        p.byte_d       = '0;
        p.packet_bytes = BytesMono;
      end
      FMT_RGB: begin
        p.byte_a       = pix[23:16];
        p.byte_b       = pix[15:8];
        p.byte_c       = pix[7:0];
        p.byte_d       = '0;
        p.packet_bytes = BytesRgb;
      end
      default: begin
        p.byte_a       = pix[23:16];
        p.byte_b       = pix[15:8];
        p.byte_c       = pix[7:0];
        p.byte_d       = pix[31:24];
        p.packet_bytes = BytesRgba;
      end
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: design/srle_ifs.sv
// Valid/ready channel interfaces for pixels, packets and configuration writes.
`default_nettype none

interface srle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_0;
  logic [7:0] sample_1;
  logic [7:0] sample_2;
  logic [7:0] sample_3;
  modport source (output valid, sample_0, sample_1, sample_2, sample_3, input ready);
  modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

interface srle_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] run_length;
  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic [7:0] byte_c;
  logic [7:0] byte_d;
  logic [2:0] packet_bytes;
  logic       last_of_item;
  modport source (output valid, run_length, byte_a, byte_b, byte_c, byte_d, packet_bytes,
                  last_of_item, input ready);
  modport sink   (input valid, run_length, byte_a, byte_b, byte_c, byte_d, packet_bytes,
                  last_of_item, output ready);
endinterface

interface srle_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/srle_core.sv
// Run tracking: compare each pixel with the open run and build the packets it closes.
`default_nettype none

module srle_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [srle_pkg::PixelW-1:0] pixel_i,
  input  wire logic [1:0]                 fmt_i,
  input  wire logic [srle_pkg::ColW-1:0]  row_len_i,
  output srle_pkg::push_t                 push_o
);
  import srle_pkg::*;

  logic [PixelW-1:0] held_pixel_q, held_pixel_d;
  logic [CountW-1:0] held_count_q, held_count_d;
  logic [ColW-1:0]   col_q, col_d;

  logic [PixelW-1:0] mask;
  logic              close_old, close_new, open_new, row_end;
  logic [CountW-1:0] run_count;
  logic [ColW-1:0]   col_inc;
  pkt_t              old_pkt, new_pkt;

  always_comb begin
    case (pix_fmt_e'(fmt_i))
      FMT_MONO: mask = 32'h0000_00FF;
      FMT_RGB:  mask = 32'h00FF_FFFF;
      default:  mask = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    close_old    = (held_count_q != '0) && (((held_pixel_q ^ pixel_i) & mask) != '0);
    open_new     = (held_count_q == '0) || close_old;
    held_pixel_d = open_new ? pixel_i : held_pixel_q;
    run_count    = open_new ? CountW'(1) : held_count_q + CountW'(1);
    col_inc      = col_q + ColW'(1);
    row_end      = (col_inc == row_len_i);
    close_new    = row_end || (run_count == RunLimit);
    held_count_d = close_new ? '0 : run_count;
    col_d        = row_end ? '0 : col_inc;

    old_pkt = build_pkt(held_pixel_q, held_count_q, fmt_i, !close_new);
    new_pkt = build_pkt(held_pixel_d, run_count, fmt_i, 1'b1);

    push_o.first  = close_old ? old_pkt : new_pkt;
    push_o.second = new_pkt;
    if (!accept_i) begin
      push_o.num = 2'd0;
    end else begin
      push_o.num = {1'b0, close_old} + {1'b0, close_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_pixel_q <= '0;
      held_count_q <= '0;
      col_q        <= '0;
    end else if (accept_i) begin
      held_pixel_q <= held_pixel_d;
      held_count_q <= held_count_d;
      col_q        <= col_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/srle_queue.sv
// Packet queue: takes up to two packets per cycle, delivers one per transaction.
`default_nettype none

module srle_queue #(
  parameter int unsigned Depth = srle_pkg::QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire srle_pkg::push_t push_i,
  input  wire logic            pop_i,
  output srle_pkg::pkt_t       head_o,
  output logic                 valid_o,
  output logic                 space_o
);
  import srle_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] SpaceMax = CntW'(Depth - 2);

  pkt_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    pop     = pop_i && valid_o;
    wr_next = bump(wr_q);
    case (push_i.num)
      2'd1:    wr_d = wr_next;
      2'd2:    wr_d = bump(wr_next);
      default: wr_d = wr_q;
    endcase
    rd_d  = pop ? bump(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != '0);
  assign space_o = (cnt_q <= SpaceMax);

endmodule

`default_nettype wire

FILE: design/scanline_pixel_rle_encoder_top.sv
// Top level of the scan-line pixel run-length encoder.
// Takes one pixel per clock and emits run packets (count plus 1, 3 or 4 sample bytes) that never
// cross a row end or exceed 255 pixels. A pixel is accepted in any cycle in which the packet
// queue has room for two packets; a pixel that closes the old run and also ends its own run
// yields two packets, which leave on two consecutive output transactions, so the sustained input
// rate is one pixel per clock except where the single-packet-per-cycle output port of the queue
// (QueueDepth entries) is the limit. A packet is queued when the pixel that closes it is accepted
// and output after the packets ahead of it. An open run at input end is held until a later pixel
// closes it. Configuration writes are taken in any cycle and apply to pixels accepted afterward.
`default_nettype none

module scanline_pixel_rle_encoder_top #(
  parameter int unsigned QueueDepth = srle_pkg::QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  srle_pix_if.sink   pix_i,
  srle_cfg_if.sink   cfg_i,
  srle_pkt_if.source pkt_o
);
  import srle_pkg::*;

  logic [1:0]        fmt_q;
  logic [ColW-1:0]   row_len_q;
  logic              accept, space;
  logic [PixelW-1:0] pixel;
  push_t             push;
  pkt_t              head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FormatReset;
      row_len_q <= RowLenReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_PIXEL_FORMAT:   fmt_q     <= cfg_i.data[1:0];
        CFG_PIXELS_PER_ROW: row_len_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = space;
  assign accept      = pix_i.valid && space;
  assign pixel       = {pix_i.sample_3, pix_i.sample_2, pix_i.sample_1, pix_i.sample_0};

  srle_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .pixel_i   (pixel),
    .fmt_i     (fmt_q),
    .row_len_i (row_len_q),
    .push_o    (push)
  );

  srle_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pkt_o.ready),
    .head_o  (head),
    .valid_o (pkt_o.valid),
    .space_o (space)
  );

  assign pkt_o.run_length   = head.run_length;
  assign pkt_o.byte_a       = head.byte_a;
  assign pkt_o.byte_b       = head.byte_b;
  assign pkt_o.byte_c       = head.byte_c;
  assign pkt_o.byte_d       = head.byte_d;
  assign pkt_o.packet_bytes = head.packet_bytes;
  assign pkt_o.last_of_item = head.last_of_item;

endmodule

`default_nettype wire
